// ===== rtl/core/rdr_pkg.sv =====
package rdr_pkg;

    localparam int AXIS_BITS  = 16;
    localparam int FRAC_BITS  = AXIS_BITS - 1;
    localparam int GUARD_BITS = 8;
    localparam int DZ_BITS    = 15;
    localparam int R2_W       = 2 * AXIS_BITS;
    localparam int V_W        = R2_W + 2 * GUARD_BITS;
    localparam int RQ_W       = V_W / 2;
    localparam int PROD_W     = AXIS_BITS + RQ_W;

    typedef struct packed {
        logic signed [AXIS_BITS-1:0] stick_x;
        logic signed [AXIS_BITS-1:0] stick_y;
    } stick_t;

    typedef struct packed {
        logic signed [AXIS_BITS-1:0] clean_x;
        logic signed [AXIS_BITS-1:0] clean_y;
    } clean_t;

    typedef struct packed {
        logic [AXIS_BITS-1:0] mx;
        logic [AXIS_BITS-1:0] my;
        logic                 nx;
        logic                 ny;
        logic                 in_dz;
        logic [FRAC_BITS-1:0] dz;
    } side_t;

    typedef struct packed {
        logic            vld;
        side_t           side;
        logic [V_W-1:0]  v;
        logic [RQ_W+2:0] rem;
        logic [RQ_W-1:0] root;
    } sqrt_beat_t;

    typedef struct packed {
        logic                 vld;
        logic                 neg;
        logic                 zero;
        logic                 sat;
        logic [PROD_W-1:0]    den;
        logic [PROD_W:0]      rem;
        logic [FRAC_BITS-1:0] q;
    } div_beat_t;

endpackage

// ===== rtl/core/radial_deadzone_rescale_unit.sv =====
// Scaled radial deadzone for one two-axis stick. Each beat on the input channel
// carries a signed Q1.15 X/Y sample and yields exactly one output beat with the
// rescaled, saturated X/Y. The unit takes one sample per clock while the
// output is not stalled. Each beat runs through the bit-per-cell
// square root chain (24 cells) followed by the bit-per-cell
// divider chains (15 cells per axis). A stalled output freezes the whole
// pipeline, so in_ready drops only while the output register holds a beat that
// is not taken. The deadzone register (APB offset 0x0, unsigned Q0.15, reset 0)
// must be written only while the unit holds no beats.
module radial_deadzone_rescale_unit (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    input  rdr_pkg::stick_t in_data,
    output logic            out_valid,
    input  logic            out_ready,
    output rdr_pkg::clean_t out_data,
    input  logic            psel,
    input  logic            penable,
    input  logic            pwrite,
    input  logic [2:0]      paddr,
    input  logic [31:0]     pwdata,
    output logic [31:0]     prdata,
    output logic            pready
);
    import rdr_pkg::*;

    localparam logic REG_DEADZONE = 1'b0;
    localparam logic [AXIS_BITS-1:0] MAG_MAX = AXIS_BITS'((1 << FRAC_BITS) - 1);
    localparam logic [AXIS_BITS-1:0] ONE     = AXIS_BITS'(1 << FRAC_BITS);

    logic [DZ_BITS-1:0]   dz_reg;
    logic [FRAC_BITS-1:0] dz_q;
    logic [FRAC_BITS+DZ_BITS-1:0] dz_wide;
    logic                 en;

    // ---------------- configuration ----------------
    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            dz_reg <= '0;
        else if (psel && penable && pwrite && paddr[2] == REG_DEADZONE)
            dz_reg <= pwdata[DZ_BITS-1:0];
    end

    assign prdata = (paddr[2] == REG_DEADZONE) ? {{(32-DZ_BITS){1'b0}}, dz_reg} : 32'd0;

    assign dz_wide = {{FRAC_BITS{1'b0}}, dz_reg};
    generate
        if (FRAC_BITS >= DZ_BITS)
        begin : g_dz_up
            localparam int SH = FRAC_BITS - DZ_BITS;
            logic [FRAC_BITS+DZ_BITS-1:0] dz_sh;
            assign dz_sh = dz_wide << SH;
            assign dz_q  = dz_sh[FRAC_BITS-1:0];
        end
        else
        begin : g_dz_down
            localparam int SH = DZ_BITS - FRAC_BITS;
            logic [FRAC_BITS+DZ_BITS-1:0] dz_sh;
            assign dz_sh = dz_wide >> SH;
            assign dz_q  = dz_sh[FRAC_BITS-1:0];
        end
    endgenerate

    // ---------------- flow control ----------------
    logic   out_vld_reg;
    clean_t out_reg;

    assign en       = !out_vld_reg || out_ready;
    assign in_ready = en;

    // ---------------- stage 1: magnitudes ----------------
    logic  s1_vld_reg;
    side_t s1_reg;
    side_t s1_next;

    always_comb
    begin
        s1_next        = '0;
        s1_next.nx     = in_data.stick_x[AXIS_BITS-1];
        s1_next.ny     = in_data.stick_y[AXIS_BITS-1];
        s1_next.mx     = s1_next.nx ? (~in_data.stick_x + 1'b1) : in_data.stick_x;
        s1_next.my     = s1_next.ny ? (~in_data.stick_y + 1'b1) : in_data.stick_y;
        s1_next.dz     = dz_q;
        s1_next.in_dz  = 1'b0;
    end

    // ---------------- stage 2: squares ----------------
    logic                   s2_vld_reg;
    side_t                  s2_reg;
    logic [R2_W-1:0]        sqx_reg;
    logic [R2_W-1:0]        sqy_reg;
    logic [2*FRAC_BITS-1:0] dz2_reg;

    // ---------------- stage 3: sum and deadzone test ----------------
    logic [R2_W-1:0] r2;
    sqrt_beat_t      sq_beat [RQ_W+1];
    sqrt_beat_t      sq0_reg;
    sqrt_beat_t      sq0_next;

    always_comb
    begin
        r2                   = sqx_reg + sqy_reg;
        sq0_next             = '0;
        sq0_next.vld         = s2_vld_reg;
        sq0_next.side        = s2_reg;
        sq0_next.side.in_dz  = (r2 == '0) || (r2 < {{(R2_W-2*FRAC_BITS){1'b0}}, dz2_reg});
        sq0_next.v           = {r2, {(2*GUARD_BITS){1'b0}}};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg  <= 1'b0;
            s2_vld_reg  <= 1'b0;
        end
        else if (en)
        begin
            s1_vld_reg  <= in_valid;
            s2_vld_reg  <= s1_vld_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            sq0_reg <= '0;
        else if (en)
            sq0_reg <= sq0_next;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_reg       <= s1_next;
            s2_reg       <= s1_reg;
            sqx_reg      <= R2_W'(s1_reg.mx * s1_reg.mx);
            sqy_reg      <= R2_W'(s1_reg.my * s1_reg.my);
            dz2_reg      <= (2*FRAC_BITS)'(s1_reg.dz * s1_reg.dz);
        end
    end

    // ---------------- square root chain ----------------
    assign sq_beat[0] = sq0_reg;

    genvar gi;
    generate
        for (gi = 0; gi < RQ_W; gi++)
        begin : g_sqrt
            rdr_sqrt_cell u_cell (
                .clk  (clk),
                .rst_n(rst_n),
                .en   (en),
                .din  (sq_beat[gi]),
                .dout (sq_beat[gi+1])
            );
        end
    endgenerate

    // ---------------- numerator and denominator products ----------------
    sqrt_beat_t        rt;
    logic [RQ_W-1:0]   diff;
    logic [AXIS_BITS-1:0] span;
    logic              m_vld_reg;
    logic              m_nx_reg;
    logic              m_ny_reg;
    logic              m_inside_reg;
    logic [PROD_W-1:0] numx_reg;
    logic [PROD_W-1:0] numy_reg;
    logic [PROD_W-1:0] den_reg;

    assign rt   = sq_beat[RQ_W];
    assign diff = rt.root - {{(RQ_W-FRAC_BITS-GUARD_BITS){1'b0}}, rt.side.dz,
                             {GUARD_BITS{1'b0}}};
    assign span = ONE - {1'b0, rt.side.dz};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_vld_reg <= 1'b0;
        else if (en)
            m_vld_reg <= rt.vld;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            m_nx_reg     <= rt.side.nx;
            m_ny_reg     <= rt.side.ny;
            m_inside_reg <= rt.side.in_dz;
            numx_reg     <= PROD_W'(rt.side.mx * diff);
            numy_reg     <= PROD_W'(rt.side.my * diff);
            den_reg      <= PROD_W'(span * rt.root);
        end
    end

    // ---------------- divider setup: saturate when quotient reaches one ----------------
    div_beat_t dx_beat [FRAC_BITS+1];
    div_beat_t dy_beat [FRAC_BITS+1];
    div_beat_t dx0_reg;
    div_beat_t dy0_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dx0_reg <= '0;
            dy0_reg <= '0;
        end
        else if (en)
        begin
            dx0_reg.vld  <= m_vld_reg;
            dy0_reg.vld  <= m_vld_reg;
            dx0_reg.neg  <= m_nx_reg;
            dx0_reg.zero <= m_inside_reg;
            dx0_reg.sat  <= numx_reg >= den_reg;
            dx0_reg.den  <= den_reg;
            dx0_reg.rem  <= {1'b0, numx_reg};
            dx0_reg.q    <= '0;
            dy0_reg.neg  <= m_ny_reg;
            dy0_reg.zero <= m_inside_reg;
            dy0_reg.sat  <= numy_reg >= den_reg;
            dy0_reg.den  <= den_reg;
            dy0_reg.rem  <= {1'b0, numy_reg};
            dy0_reg.q    <= '0;
        end
    end

    assign dx_beat[0] = dx0_reg;
    assign dy_beat[0] = dy0_reg;

    generate
        for (gi = 0; gi < FRAC_BITS; gi++)
        begin : g_div
            rdr_div_cell u_cell_x (
                .clk  (clk),
                .rst_n(rst_n),
                .en   (en),
                .din  (dx_beat[gi]),
                .dout (dx_beat[gi+1])
            );
            rdr_div_cell u_cell_y (
                .clk  (clk),
                .rst_n(rst_n),
                .en   (en),
                .din  (dy_beat[gi]),
                .dout (dy_beat[gi+1])
            );
        end
    endgenerate

    // ---------------- output register ----------------
    div_beat_t            fx;
    div_beat_t            fy;
    logic [AXIS_BITS-1:0] magx;
    logic [AXIS_BITS-1:0] magy;
    clean_t               out_next;

    assign fx = dx_beat[FRAC_BITS];
    assign fy = dy_beat[FRAC_BITS];

    always_comb
    begin
        magx = fx.sat ? MAG_MAX : {1'b0, fx.q};
        magy = fy.sat ? MAG_MAX : {1'b0, fy.q};
        if (fx.zero)
            magx = '0;
        if (fy.zero)
            magy = '0;
        out_next.clean_x = fx.neg ? (~magx + 1'b1) : magx;
        out_next.clean_y = fy.neg ? (~magy + 1'b1) : magy;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_vld_reg <= 1'b0;
        else if (en)
            out_vld_reg <= fx.vld;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            out_reg <= out_next;
    end

    assign out_valid = out_vld_reg;
    assign out_data  = out_reg;

endmodule

// ===== rtl/core/rdr_sqrt_cell.sv =====
module rdr_sqrt_cell (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               en,
    input  rdr_pkg::sqrt_beat_t din,
    output rdr_pkg::sqrt_beat_t dout
);
    import rdr_pkg::*;

    sqrt_beat_t      beat_reg;
    sqrt_beat_t      beat_next;
    logic [RQ_W+2:0] acc;
    logic [RQ_W+2:0] trial;

    // one root bit per cell: bring down two radicand bits, try 4*root+1
    always_comb
    begin
        acc       = {din.rem[RQ_W:0], din.v[V_W-1 -: 2]};
        trial     = {1'b0, din.root, 2'b01};
        beat_next = din;
        beat_next.v = din.v << 2;
        if (acc >= trial)
        begin
            beat_next.rem  = acc - trial;
            beat_next.root = {din.root[RQ_W-2:0], 1'b1};
        end
        else
        begin
            beat_next.rem  = acc;
            beat_next.root = {din.root[RQ_W-2:0], 1'b0};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            beat_reg <= '0;
        else if (en)
            beat_reg <= beat_next;
    end

    assign dout = beat_reg;

endmodule

// ===== rtl/core/rdr_div_cell.sv =====
module rdr_div_cell (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  rdr_pkg::div_beat_t din,
    output rdr_pkg::div_beat_t dout
);
    import rdr_pkg::*;

    div_beat_t       beat_reg;
    div_beat_t       beat_next;
    logic [PROD_W:0] rem2;

    // one quotient bit per cell, restoring step
    always_comb
    begin
        rem2      = {din.rem[PROD_W-1:0], 1'b0};
        beat_next = din;
        if (rem2 >= {1'b0, din.den})
        begin
            beat_next.rem = rem2 - {1'b0, din.den};
            beat_next.q   = {din.q[FRAC_BITS-2:0], 1'b1};
        end
        else
        begin
            beat_next.rem = rem2;
            beat_next.q   = {din.q[FRAC_BITS-2:0], 1'b0};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            beat_reg <= '0;
        else if (en)
            beat_reg <= beat_next;
    end

    assign dout = beat_reg;

endmodule
